// File: rtl/swsc_pkg.sv
// Shared types and constants of the congestion-controlled sack window sender.
`timescale 1ns / 1ps
`default_nettype none
package swsc_pkg;

  localparam int MAX_SEGS        = 1024;
  localparam int FRAC_BITS       = 16;
  localparam int SEG_W           = 11;
  localparam int ADDR_W          = $clog2(MAX_SEGS);
  localparam int WIN_W           = SEG_W + FRAC_BITS;
  localparam int TMR_W           = 16;
  localparam int DUP_W           = 8;
  localparam int CMD_W           = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int QUO_W           = FRAC_BITS + 1;
  localparam int DUP_RESEND      = 3;
  localparam int RESET_THRESHOLD = 16;
  localparam int RESET_TOTAL     = 1;
  localparam int RESET_TIMEOUT   = 1000;

  localparam logic [WIN_W-1:0] WIN_ONE = WIN_W'(1) << FRAC_BITS;
  localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(MAX_SEGS) << FRAC_BITS;
  localparam logic [DUP_W-1:0] DUP_MAX = {DUP_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_TOTAL = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_INIT_THR  = 2'd2
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic start_init;
    logic sack_mark;
    logic ack_new;
    logic div_start;
    logic avoid_add;
    logic dup_inc;
    logic walk_init;
    logic walk_rd;
    logic walk_ev;
    logic resend;
    logic ack_end;
    logic tick;
    logic slot;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             clr_last;
    logic [CMD_W-1:0] item_cmd;
    logic             is_new;
    logic             avoid;
    logic             div_done;
    logic             walk_end;
    logic             walk_stop;
    logic             dup_send;
    logic             dup_is3;
    logic             tick_expire;
    logic             two_results;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/swsc_if.sv
// Input and result channel interfaces of the sack window sender.
`timescale 1ns / 1ps
`default_nettype none
interface swsc_in_if;
  logic                       valid;
  logic                       ready;
  logic [swsc_pkg::CMD_W-1:0] command;
  logic [swsc_pkg::SEG_W-1:0] ack_number;
  logic [swsc_pkg::SEG_W-1:0] sack_number;

  modport source (output valid, command, ack_number, sack_number, input ready);
  modport sink   (input valid, command, ack_number, sack_number, output ready);
endinterface

interface swsc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       send_valid;
  logic [swsc_pkg::SEG_W-1:0] segment_number;
  logic                       is_resend;
  logic [swsc_pkg::SEG_W-1:0] window_size;
  logic [swsc_pkg::SEG_W-1:0] threshold_now;
  logic                       timed_out;
  logic                       all_acked;
  logic                       last;

  modport source (output valid, send_valid, segment_number, is_resend, window_size,
                  threshold_now, timed_out, all_acked, last, input ready);
  modport sink   (input valid, send_valid, segment_number, is_resend, window_size,
                  threshold_now, timed_out, all_acked, last, output ready);
endinterface
`default_nettype wire

// File: rtl/swsc_div.sv
// Restoring divider, one quotient bit per cycle: 1.0 in fixed point over the window.
`timescale 1ns / 1ps
`default_nettype none
module swsc_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [swsc_pkg::SEG_W-1:0]     divisor_i,
  output logic                                done_o,
  output logic      [swsc_pkg::QUO_W-1:0]     quotient_o
);
  localparam int STEP_W = $clog2(swsc_pkg::QUO_W);

  logic                         busy_q, done_q;
  logic [STEP_W-1:0]            step_q;
  logic [swsc_pkg::QUO_W-1:0]   num_q, quo_q;
  logic [swsc_pkg::SEG_W-1:0]   div_q, rem_q;
  logic [swsc_pkg::SEG_W:0]     rem_s;
  logic                         fit;

  assign rem_s = {rem_q, num_q[swsc_pkg::QUO_W-1]};
  assign fit   = rem_s >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(swsc_pkg::QUO_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= swsc_pkg::QUO_W'(1) << swsc_pkg::FRAC_BITS;
      rem_q <= '0;
      quo_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fit ? swsc_pkg::SEG_W'(rem_s - {1'b0, div_q})
                   : rem_s[swsc_pkg::SEG_W-1:0];
      quo_q <= {quo_q[swsc_pkg::QUO_W-2:0], fit};
      num_q <= num_q << 1;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// File: rtl/swsc_dp.sv
// Datapath: window state, acked bitmap memory, window walk, result slots.
`timescale 1ns / 1ps
`default_nettype none
module swsc_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [swsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [swsc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [swsc_pkg::CMD_W-1:0]          command_i,
  input  wire logic [swsc_pkg::SEG_W-1:0]          ack_number_i,
  input  wire logic [swsc_pkg::SEG_W-1:0]          sack_number_i,
  input  wire swsc_pkg::dp_cmd_t                   cmd_i,
  output swsc_pkg::dp_stat_t                       stat_o,
  output logic                                     send_valid_o,
  output logic      [swsc_pkg::SEG_W-1:0]          segment_number_o,
  output logic                                     is_resend_o,
  output logic      [swsc_pkg::SEG_W-1:0]          window_size_o,
  output logic      [swsc_pkg::SEG_W-1:0]          threshold_now_o,
  output logic                                     timed_out_o,
  output logic                                     all_acked_o,
  output logic                                     last_o
);
  localparam int SEG_W  = swsc_pkg::SEG_W;
  localparam int WIN_W  = swsc_pkg::WIN_W;
  localparam int ADDR_W = swsc_pkg::ADDR_W;
  localparam int SUM_W  = SEG_W + 2;

  // configuration
  logic [SEG_W-1:0]           seg_total_q, init_thr_q;
  logic [swsc_pkg::TMR_W-1:0] timeout_q;

  // protocol state
  logic [WIN_W-1:0]           window_q;
  logic [SEG_W-1:0]           thr_q, base_q, hs_q, acked_q;
  logic [swsc_pkg::DUP_W-1:0] dup_q;
  logic                       avoid_q;
  logic [swsc_pkg::TMR_W-1:0] timer_q;
  logic [ADDR_W-1:0]          clr_q;

  // per item
  logic [swsc_pkg::CMD_W-1:0] item_cmd_q;
  logic [SEG_W-1:0]           ack_q, sack_q, before_q, k_q, cnt_q, seg0_q, seg1_q;
  logic [SEG_W:0]             walk_num_q;
  logic                       new_q, timed_q, rs0_q, rs1_q;
  logic [1:0]                 n_q;

  // bitmap memory
  logic                       map_mem [swsc_pkg::MAX_SEGS];
  logic                       mem_we, mem_wd, rd_q;
  logic [ADDR_W-1:0]          mem_wa, mem_ra, sack_addr, walk_addr;

  logic [SEG_W-1:0]           total, win_int, cnt_n, grow, half;
  logic                       all_acked, sack_ok, base_ok, tail_hit, walk_end;
  logic [WIN_W-1:0]           ss_sum, ss_win, av_sum, av_win;
  logic [swsc_pkg::QUO_W-1:0] quotient;
  logic                       div_done;
  logic                       push_en, push_rs;
  logic [SEG_W-1:0]           push_seg;

  assign total     = (seg_total_q > SEG_W'(swsc_pkg::MAX_SEGS)) ?
                     SEG_W'(swsc_pkg::MAX_SEGS) : seg_total_q;
  assign win_int   = window_q[WIN_W-1:swsc_pkg::FRAC_BITS];
  assign all_acked = acked_q >= total;
  assign sack_ok   = (sack_q != '0) && (sack_q <= total);
  assign base_ok   = (base_q != '0) && (base_q <= total);
  assign sack_addr = ADDR_W'(sack_q - 1'b1);
  assign walk_addr = ADDR_W'(k_q - 1'b1);
  assign half      = win_int >> 1;
  assign grow      = win_int - before_q;

  // window growth, both clamped at the segment limit
  assign ss_sum = window_q + swsc_pkg::WIN_ONE;
  assign ss_win = (ss_sum > swsc_pkg::WIN_CAP) ? swsc_pkg::WIN_CAP : ss_sum;
  assign av_sum = window_q + WIN_W'(quotient);
  assign av_win = (av_sum > swsc_pkg::WIN_CAP) ? swsc_pkg::WIN_CAP : av_sum;

  // walk: count unacked slots from base, send the trailing ones
  assign walk_end = (k_q == '0) || (k_q > total);
  assign cnt_n    = cnt_q + 1'b1;
  assign tail_hit = (SUM_W'(cnt_n) + SUM_W'(walk_num_q)) > SUM_W'(win_int);

  swsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .divisor_i  ((win_int == '0) ? SEG_W'(1) : win_int),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign mem_we = cmd_i.clr | (cmd_i.sack_mark & sack_ok & ~rd_q);
  assign mem_wa = cmd_i.clr ? clr_q : sack_addr;
  assign mem_wd = ~cmd_i.clr;
  assign mem_ra = cmd_i.walk_rd ? walk_addr : sack_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_q <= map_mem[mem_ra];
  end

  always_comb begin
    push_en  = 1'b0;
    push_seg = k_q;
    push_rs  = k_q <= hs_q;
    if (cmd_i.walk_ev && !rd_q && tail_hit) begin
      push_en = 1'b1;
    end
    if (cmd_i.resend && base_ok) begin
      push_en  = 1'b1;
      push_seg = base_q;
      push_rs  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_total_q <= SEG_W'(swsc_pkg::RESET_TOTAL);
      timeout_q   <= swsc_pkg::TMR_W'(swsc_pkg::RESET_TIMEOUT);
      init_thr_q  <= SEG_W'(swsc_pkg::RESET_THRESHOLD);
      window_q    <= swsc_pkg::WIN_ONE;
      thr_q       <= SEG_W'(swsc_pkg::RESET_THRESHOLD);
      dup_q       <= '0;
      base_q      <= SEG_W'(1);
      hs_q        <= '0;
      acked_q     <= '0;
      avoid_q     <= 1'b0;
      timer_q     <= '0;
      clr_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          swsc_pkg::CFG_SEG_TOTAL: seg_total_q <= cfg_data_i[SEG_W-1:0];
          swsc_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data_i[swsc_pkg::TMR_W-1:0];
          swsc_pkg::CFG_INIT_THR:  init_thr_q  <= cfg_data_i[SEG_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.start_init) begin
        window_q <= swsc_pkg::WIN_ONE;
        thr_q    <= init_thr_q;
        dup_q    <= '0;
        base_q   <= SEG_W'(1);
        hs_q     <= '0;
        acked_q  <= '0;
        avoid_q  <= 1'b0;
        timer_q  <= timeout_q;
      end
      if (cmd_i.sack_mark && sack_ok && !rd_q) begin
        acked_q <= acked_q + 1'b1;
      end
      if (cmd_i.ack_new) begin
        dup_q   <= '0;
        base_q  <= ((ack_q > total) ? total : ack_q) + 1'b1;
        timer_q <= timeout_q;
        if (!avoid_q) begin
          window_q <= ss_win;
          if (ss_win >= (WIN_W'(thr_q) << swsc_pkg::FRAC_BITS)) begin
            avoid_q <= 1'b1;
          end
        end
      end
      if (cmd_i.avoid_add) begin
        window_q <= av_win;
      end
      if (cmd_i.dup_inc && dup_q != swsc_pkg::DUP_MAX) begin
        dup_q <= dup_q + 1'b1;
      end
      if (cmd_i.walk_ev && !rd_q && tail_hit && k_q > hs_q) begin
        hs_q <= k_q;
      end
      if (cmd_i.ack_end && all_acked) begin
        timer_q <= '0;
      end
      if (cmd_i.tick && timer_q != '0) begin
        timer_q <= timer_q - 1'b1;
        if (stat_o.tick_expire) begin
          thr_q    <= (half == '0) ? SEG_W'(1) : half;
          window_q <= swsc_pkg::WIN_ONE;
          dup_q    <= '0;
          avoid_q  <= 1'b0;
          timer_q  <= timeout_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_cmd_q <= command_i;
      ack_q      <= ack_number_i;
      sack_q     <= sack_number_i;
      new_q      <= ack_number_i >= base_q;
      n_q        <= '0;
      timed_q    <= 1'b0;
    end
    if (cmd_i.ack_new) begin
      before_q <= win_int;
    end
    if (cmd_i.walk_init) begin
      k_q        <= base_q;
      cnt_q      <= '0;
      walk_num_q <= (item_cmd_q == swsc_pkg::CMD_ACK && new_q) ?
                    {1'b0, grow} + 1'b1 : (SEG_W + 1)'(1);
    end
    if (cmd_i.walk_ev) begin
      k_q <= k_q + 1'b1;
      if (!rd_q) begin
        cnt_q <= cnt_n;
      end
    end
    if (cmd_i.tick && stat_o.tick_expire) begin
      timed_q <= 1'b1;
    end
    if (push_en && n_q != 2'd2) begin
      n_q <= n_q + 1'b1;
      if (n_q == 2'd0) begin
        seg0_q <= push_seg;
        rs0_q  <= push_rs;
      end else begin
        seg1_q <= push_seg;
        rs1_q  <= push_rs;
      end
    end
  end

  always_comb begin
    stat_o             = '0;
    stat_o.clr_last    = clr_q == {ADDR_W{1'b1}};
    stat_o.item_cmd    = item_cmd_q;
    stat_o.is_new      = new_q;
    stat_o.avoid       = avoid_q;
    stat_o.div_done    = div_done;
    stat_o.walk_end    = walk_end;
    stat_o.walk_stop   = !rd_q && (cnt_n >= win_int);
    stat_o.dup_send    = !(((SUM_W'(base_q) + SUM_W'(win_int) - 1'b1) >= SUM_W'(total)) ||
                           (ack_q == sack_q));
    stat_o.dup_is3     = dup_q == swsc_pkg::DUP_W'(swsc_pkg::DUP_RESEND);
    stat_o.tick_expire = (timer_q == swsc_pkg::TMR_W'(1)) && !all_acked;
    stat_o.two_results = n_q == 2'd2;
  end

  logic have;
  assign have             = cmd_i.slot ? (n_q == 2'd2) : (n_q != 2'd0);
  assign send_valid_o     = have;
  assign segment_number_o = have ? (cmd_i.slot ? seg1_q : seg0_q) : '0;
  assign is_resend_o      = have & (cmd_i.slot ? rs1_q : rs0_q);
  assign window_size_o    = win_int;
  assign threshold_now_o  = thr_q;
  assign timed_out_o      = timed_q;
  assign all_acked_o      = all_acked;
  assign last_o           = cmd_i.slot | (n_q != 2'd2);
endmodule
`default_nettype wire

// File: rtl/swsc_ctrl.sv
// Controller state machine: sequences clear, sack mark, window update, walk, resend, tick and results.
`timescale 1ns / 1ps
`default_nettype none
module swsc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output swsc_pkg::dp_cmd_t        cmd_o,
  input  wire swsc_pkg::dp_stat_t  stat_i
);
  typedef enum logic [19:0] {
    ST_BOOT_CLR   = 20'h00001,
    ST_IDLE       = 20'h00002,
    ST_DECODE     = 20'h00004,
    ST_START_CLR  = 20'h00008,
    ST_START_INIT = 20'h00010,
    ST_SACK_RD    = 20'h00020,
    ST_SACK_EV    = 20'h00040,
    ST_ACK_NEW    = 20'h00080,
    ST_DIV_WAIT   = 20'h00100,
    ST_AVOID_ADD  = 20'h00200,
    ST_DUP_INC    = 20'h00400,
    ST_DUP_CHK    = 20'h00800,
    ST_WALK_INIT  = 20'h01000,
    ST_WALK_RD    = 20'h02000,
    ST_WALK_EV    = 20'h04000,
    ST_RESEND     = 20'h08000,
    ST_ACK_END    = 20'h10000,
    ST_TICK       = 20'h20000,
    ST_EMIT_A     = 20'h40000,
    ST_EMIT_B     = 20'h80000
  } state_e;

  state_e state_q, state_d, walk_exit, resend_exit;
  logic   is_ack;

  assign is_ack = stat_i.item_cmd == swsc_pkg::CMD_ACK;

  always_comb begin
    priority if (is_ack && !stat_i.is_new && stat_i.dup_is3) walk_exit = ST_RESEND;
    else if (is_ack) walk_exit = ST_ACK_END;
    else walk_exit = ST_EMIT_A;
  end

  assign resend_exit = is_ack ? ST_ACK_END : ST_EMIT_A;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_BOOT_CLR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (stat_i.item_cmd == swsc_pkg::CMD_START) state_d = ST_START_CLR;
        else if (is_ack) state_d = ST_SACK_RD;
        else if (stat_i.item_cmd == swsc_pkg::CMD_TICK) state_d = ST_TICK;
        else state_d = ST_EMIT_A;
      end
      ST_START_CLR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = ST_START_INIT;
      end
      ST_START_INIT: begin
        cmd_o.start_init = 1'b1;
        state_d          = ST_WALK_INIT;
      end
      ST_SACK_RD: state_d = ST_SACK_EV;
      ST_SACK_EV: begin
        cmd_o.sack_mark = 1'b1;
        state_d         = stat_i.is_new ? ST_ACK_NEW : ST_DUP_INC;
      end
      ST_ACK_NEW: begin
        cmd_o.ack_new = 1'b1;
        if (stat_i.avoid) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV_WAIT;
        end else begin
          state_d = ST_WALK_INIT;
        end
      end
      ST_DIV_WAIT: begin
        if (stat_i.div_done) state_d = ST_AVOID_ADD;
      end
      ST_AVOID_ADD: begin
        cmd_o.avoid_add = 1'b1;
        state_d         = ST_WALK_INIT;
      end
      ST_DUP_INC: begin
        cmd_o.dup_inc = 1'b1;
        state_d       = ST_DUP_CHK;
      end
      ST_DUP_CHK: begin
        priority if (stat_i.dup_send) state_d = ST_WALK_INIT;
        else if (stat_i.dup_is3) state_d = ST_RESEND;
        else state_d = ST_ACK_END;
      end
      ST_WALK_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        if (stat_i.walk_end) begin
          state_d = walk_exit;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d       = ST_WALK_EV;
        end
      end
      ST_WALK_EV: begin
        cmd_o.walk_ev = 1'b1;
        state_d       = stat_i.walk_stop ? walk_exit : ST_WALK_RD;
      end
      ST_RESEND: begin
        cmd_o.resend = 1'b1;
        state_d      = resend_exit;
      end
      ST_ACK_END: begin
        cmd_o.ack_end = 1'b1;
        state_d       = ST_EMIT_A;
      end
      ST_TICK: begin
        cmd_o.tick = 1'b1;
        state_d    = stat_i.tick_expire ? ST_RESEND : ST_EMIT_A;
      end
      ST_EMIT_A: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = stat_i.two_results ? ST_EMIT_B : ST_IDLE;
      end
      ST_EMIT_B: begin
        out_valid_o = 1'b1;
        cmd_o.slot  = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT_CLR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/sack_window_sender_congestion.sv
// Top level of the congestion-controlled sliding window sender with selective acks.
`timescale 1ns / 1ps
`default_nettype none
// Takes one command at a time (start, ack, tick) and returns one or two result
// transfers, the last one flagged. After reset the acked bitmap memory is
// cleared one entry per cycle, all 1024 entries, before the first command is
// taken; a start command runs the same clear. An ack walks the window slots
// through the bitmap memory (up to the window size plus acked slots
// skipped), and in congestion avoidance also runs the serial divider and
// the window add. Each result then waits for its transfer on the output
// channel.
// Configuration writes may happen at any time the block is idle.
module sack_window_sender_congestion (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  swsc_in_if.sink                                in_i,
  swsc_out_if.source                             out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [swsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [swsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  swsc_pkg::dp_cmd_t  dp_cmd;
  swsc_pkg::dp_stat_t dp_stat;

  swsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  swsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (in_i.command),
    .ack_number_i     (in_i.ack_number),
    .sack_number_i    (in_i.sack_number),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .send_valid_o     (out_o.send_valid),
    .segment_number_o (out_o.segment_number),
    .is_resend_o      (out_o.is_resend),
    .window_size_o    (out_o.window_size),
    .threshold_now_o  (out_o.threshold_now),
    .timed_out_o      (out_o.timed_out),
    .all_acked_o      (out_o.all_acked),
    .last_o           (out_o.last)
  );

  // one item in flight: no input while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while result pending");

  // last transfer ends the item
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> !out_o.valid)
    else $error("result shown after last transfer");

  // window never below one segment
  a_window_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.window_size != '0 && out_o.threshold_now != '0
                     || out_o.window_size != '0))
    else $error("window size zero");

  // status-only results carry no segment
  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.send_valid) |-> (out_o.segment_number == '0 && !out_o.is_resend))
    else $error("status result carries segment");
endmodule
`default_nettype wire
